// File: rtl/core/sspc_pkg.sv
`timescale 1ns / 1ps

package sspc_pkg;

  // Default limit on parameter bytes in one status reply.
  localparam int MAX_PARAMS_DEF = 8;

  // Header byte that opens every reply, twice.
  localparam logic [7:0] HDR_BYTE = 8'hFF;

  // Reset value of the expected servo identifier.
  localparam logic [7:0] EXPECTED_ID_RST = 8'd1;

  // Status codes that are not taken from the servo error byte.
  localparam logic [3:0] ST_OK       = 4'd0;
  localparam logic [3:0] ST_CSUM_BAD = 4'd8;
  localparam logic [3:0] ST_START_ID = 4'd9;
  localparam logic [3:0] ST_LENGTH   = 4'd10;

  // Number of error bits that map to a servo status.
  localparam int ERR_BITS = 7;

  // One received reply byte.
  typedef struct packed {
    logic [7:0] rx_byte;
    logic       frame_start;
  } item_t;

  // One status result.
  typedef struct packed {
    logic [3:0]  status;
    logic [7:0]  servo_error;
    logic [15:0] param_word;
    logic [3:0]  param_count;
  } result_t;

endpackage

// File: rtl/core/sspc_in_reg.sv
`timescale 1ns / 1ps

module sspc_in_reg (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [7:0]          in_rx_byte,
  input  logic                in_frame_start,
  input  logic                take,
  output logic                item_valid,
  output sspc_pkg::item_t     item
);

  logic            valid_r;
  logic            valid_nxt;
  sspc_pkg::item_t item_r;
  logic            accept;

  // The register can load when it is empty or its byte is consumed this cycle.
  assign in_stall  = valid_r && !take;
  assign accept    = in_valid && !in_stall;
  assign valid_nxt = accept ? 1'b1 : (take ? 1'b0 : valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload capture needs no reset.
  always_ff @(posedge clk) begin
    if (accept) begin
      item_r.rx_byte     <= in_rx_byte;
      item_r.frame_start <= in_frame_start;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

`ifndef ASSERT_OFF
  // A held byte that is not consumed must stay in place.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && !take) |=> (valid_r && $stable(item_r)))
    else $error("input register lost a pending byte");

  // The consumer only takes a byte that is present.
  a_take: assert property (@(posedge clk) disable iff (!rst_n)
    take |-> valid_r)
    else $error("byte taken from empty input register");
`endif

endmodule

// File: rtl/core/sspc_parser.sv
`timescale 1ns / 1ps

module sspc_parser #(
  parameter int MAX_PARAMS = sspc_pkg::MAX_PARAMS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step_en,
  input  sspc_pkg::item_t     item,
  input  logic [7:0]          expected_id,
  output logic                res_valid,
  output sspc_pkg::result_t   res
);

  localparam int PIDX_W = $clog2(MAX_PARAMS + 1);
  localparam logic [8:0] LEN_MAX = 9'(MAX_PARAMS + 2);

  typedef enum logic [7:0] {
    PH_IDLE  = 8'b0000_0001,
    PH_HDR2  = 8'b0000_0010,
    PH_ID    = 8'b0000_0100,
    PH_LEN   = 8'b0000_1000,
    PH_ERR   = 8'b0001_0000,
    PH_PARAM = 8'b0010_0000,
    PH_CHK   = 8'b0100_0000,
    PH_DROP  = 8'b1000_0000
  } phase_t;

  phase_t              phase_r, phase_nxt;
  logic [PIDX_W-1:0]   param_index_r, param_index_nxt;
  logic [7:0]          running_sum_r, running_sum_nxt;
  logic [7:0]          frame_length_r, frame_length_nxt;
  logic [7:0]          error_byte_r, error_byte_nxt;
  logic [7:0]          param_low_r, param_low_nxt;
  logic [7:0]          param_high_r, param_high_nxt;

  logic [7:0]          b;
  logic [PIDX_W-1:0]   idx_inc;
  logic                len_bad;
  logic                last_param;
  logic [3:0]          err_status;

  assign b       = item.rx_byte;
  assign idx_inc = param_index_r + 1'b1;
  assign len_bad = (b < 8'd2) || (9'(b) > LEN_MAX);
  assign last_param = 9'(idx_inc) >= (9'(frame_length_r) - 9'd2);

  // Lowest set bit among the low seven error bits, plus one; zero if none.
  always_comb begin
    err_status = sspc_pkg::ST_OK;
    for (int i = sspc_pkg::ERR_BITS - 1; i >= 0; i--) begin
      if (error_byte_r[i]) begin
        err_status = 4'(i + 1);
      end
    end
  end

  // Frame walk and result decode for one byte.
  always_comb begin
    phase_nxt        = phase_r;
    param_index_nxt  = param_index_r;
    running_sum_nxt  = running_sum_r;
    frame_length_nxt = frame_length_r;
    error_byte_nxt   = error_byte_r;
    param_low_nxt    = param_low_r;
    param_high_nxt   = param_high_r;
    res_valid        = 1'b0;
    res              = '0;
    if (step_en) begin
      if (item.frame_start) begin
        param_index_nxt  = '0;
        running_sum_nxt  = '0;
        frame_length_nxt = '0;
        error_byte_nxt   = '0;
        param_low_nxt    = '0;
        param_high_nxt   = '0;
        if (b != sspc_pkg::HDR_BYTE) begin
          phase_nxt  = PH_DROP;
          res_valid  = 1'b1;
          res.status = sspc_pkg::ST_START_ID;
        end else begin
          phase_nxt = PH_HDR2;
        end
      end else begin
        unique case (phase_r)
          PH_HDR2: begin
            if (b != sspc_pkg::HDR_BYTE) begin
              phase_nxt  = PH_DROP;
              res_valid  = 1'b1;
              res.status = sspc_pkg::ST_START_ID;
            end else begin
              phase_nxt = PH_ID;
            end
          end
          PH_ID: begin
            if (b != expected_id) begin
              phase_nxt  = PH_DROP;
              res_valid  = 1'b1;
              res.status = sspc_pkg::ST_START_ID;
            end else begin
              running_sum_nxt = b;
              phase_nxt       = PH_LEN;
            end
          end
          PH_LEN: begin
            if (len_bad) begin
              phase_nxt  = PH_DROP;
              res_valid  = 1'b1;
              res.status = sspc_pkg::ST_LENGTH;
            end else begin
              frame_length_nxt = b;
              running_sum_nxt  = running_sum_r + b;
              phase_nxt        = PH_ERR;
            end
          end
          PH_ERR: begin
            error_byte_nxt  = b;
            running_sum_nxt = running_sum_r + b;
            phase_nxt       = (frame_length_r == 8'd2) ? PH_CHK : PH_PARAM;
          end
          PH_PARAM: begin
            if (param_index_r == PIDX_W'(0)) begin
              param_low_nxt = b;
            end else if (param_index_r == PIDX_W'(1)) begin
              param_high_nxt = b;
            end
            running_sum_nxt = running_sum_r + b;
            param_index_nxt = idx_inc;
            if (last_param) begin
              phase_nxt = PH_CHK;
            end
          end
          PH_CHK: begin
            phase_nxt       = PH_IDLE;
            res_valid       = 1'b1;
            res.servo_error = error_byte_r;
            res.param_word  = {param_high_r, param_low_r};
            res.param_count = 4'(frame_length_r - 8'd2);
            if (err_status != sspc_pkg::ST_OK) begin
              res.status = err_status;
            end else if (b != ~running_sum_r) begin
              res.status = sspc_pkg::ST_CSUM_BAD;
            end else begin
              res.status = sspc_pkg::ST_OK;
            end
          end
          PH_IDLE, PH_DROP: begin
            phase_nxt = phase_r;
          end
          default: begin
            phase_nxt = PH_IDLE;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= PH_IDLE;
      param_index_r  <= '0;
      running_sum_r  <= '0;
      frame_length_r <= '0;
      error_byte_r   <= '0;
      param_low_r    <= '0;
      param_high_r   <= '0;
    end else begin
      phase_r        <= phase_nxt;
      param_index_r  <= param_index_nxt;
      running_sum_r  <= running_sum_nxt;
      frame_length_r <= frame_length_nxt;
      error_byte_r   <= error_byte_nxt;
      param_low_r    <= param_low_nxt;
      param_high_r   <= param_high_nxt;
    end
  end

`ifndef ASSERT_OFF
  // A stray byte while idle or dropping never makes a result.
  a_stray: assert property (@(posedge clk) disable iff (!rst_n)
    (step_en && !item.frame_start && (phase_r == PH_IDLE || phase_r == PH_DROP))
      |-> !res_valid)
    else $error("result from a stray byte");

  // Every framing fault leaves the walker dropping bytes.
  a_fault: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && (res.status == sspc_pkg::ST_START_ID ||
                   res.status == sspc_pkg::ST_LENGTH)) |=> (phase_r == PH_DROP))
    else $error("fault did not enter drop phase");

  // The parameter counter stays inside the declared length.
  a_pidx: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_PARAM) |-> (9'(param_index_r) < (9'(frame_length_r) - 9'd2)))
    else $error("parameter index beyond frame length");
`endif

endmodule

// File: rtl/core/sspc_out_reg.sv
`timescale 1ns / 1ps

module sspc_out_reg (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                load,
  input  sspc_pkg::result_t   res,
  output logic                out_valid,
  input  logic                out_stall,
  output sspc_pkg::result_t   out_res
);

  logic              valid_r;
  logic              valid_nxt;
  sspc_pkg::result_t res_r;

  // A result stays until the consumer stops stalling; a load only happens into a free slot.
  assign valid_nxt = load || (valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

`ifndef ASSERT_OFF
  // Never overwrite a result that is still stalled.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> !(valid_r && out_stall))
    else $error("result register overwritten while stalled");
`endif

endmodule

// File: rtl/core/servo_status_packet_checker.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake          Payload
// in_       request    in_valid/in_stall  in_rx_byte[7:0], in_frame_start
// out_      result     out_valid/out_stall out_status[3:0], out_servo_error[7:0],
//                                          out_param_word[15:0], out_param_count[3:0]
// cfg_      write      cfg_valid/cfg_ready cfg_expected_id[7:0]
//
// One byte per cycle is taken while no result is stalled at the output; each byte passes
// the input register, the frame walker and the result register.
// A result stalled at the output is held while one more byte waits in the input register.
// Reset is synchronous and active low; it sets the expected id to 1 and idles the walker.
// The configuration port is always ready.

module servo_status_packet_checker #(
  parameter int MAX_PARAMS = sspc_pkg::MAX_PARAMS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  input  logic        in_frame_start,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  out_status,
  output logic [7:0]  out_servo_error,
  output logic [15:0] out_param_word,
  output logic [3:0]  out_param_count,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_expected_id
);

  logic              item_valid;
  sspc_pkg::item_t   item;
  logic              take;
  logic              res_valid;
  sspc_pkg::result_t res;
  sspc_pkg::result_t out_res;
  logic [7:0]        expected_id_r;

  // Expected id register.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expected_id_r <= sspc_pkg::EXPECTED_ID_RST;
    end else if (cfg_valid && cfg_ready) begin
      expected_id_r <= cfg_expected_id;
    end
  end

  sspc_in_reg u_in_reg (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_rx_byte     (in_rx_byte),
    .in_frame_start (in_frame_start),
    .take           (take),
    .item_valid     (item_valid),
    .item           (item)
  );

  // A byte is processed when the result register is free or being drained.
  assign take = item_valid && (!out_valid || !out_stall);

  sspc_parser #(
    .MAX_PARAMS (MAX_PARAMS)
  ) u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .step_en     (take),
    .item        (item),
    .expected_id (expected_id_r),
    .res_valid   (res_valid),
    .res         (res)
  );

  sspc_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (res_valid),
    .res       (res),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign out_status      = out_res.status;
  assign out_servo_error = out_res.servo_error;
  assign out_param_word  = out_res.param_word;
  assign out_param_count = out_res.param_count;

endmodule

// File: dv/tb_servo_status_packet_checker.sv
`timescale 1ns / 1ps

// Steps of the reply walker, as the checker sees a status packet.
typedef enum logic [2:0] {
  WALK_IDLE,
  WALK_HDR2,
  WALK_ID,
  WALK_LEN,
  WALK_ERR,
  WALK_PARAM,
  WALK_CHK,
  WALK_DROP
} walk_t;

// Follows the reply walker byte by byte and keeps the statuses still to come.
class reply_status_tracker;
  localparam int MAX_PARAMS = sspc_pkg::MAX_PARAMS_DEF;

  logic [7:0]         want_id;
  walk_t              walk;
  int unsigned        param_idx;
  logic [7:0]         sum;
  logic [7:0]         len_byte;
  logic [7:0]         err_byte;
  logic [7:0]         p_lo;
  logic [7:0]         p_hi;
  sspc_pkg::result_t  status_q[$];
  int unsigned        fails;

  function new();
    want_id = sspc_pkg::EXPECTED_ID_RST;
    walk = WALK_IDLE;
    fails = 0;
    clear_frame();
  endfunction

  function void clear_frame();
    param_idx = 0;
    sum = '0;
    len_byte = '0;
    err_byte = '0;
    p_lo = '0;
    p_hi = '0;
  endfunction

  function void set_id(logic [7:0] v);
    want_id = v;
  endfunction

  function int unsigned pending();
    return status_q.size();
  endfunction

  // A framing fault reports with empty payload fields and drops the rest.
  function void fault(logic [3:0] st);
    sspc_pkg::result_t r;
    r.status = st;
    r.servo_error = '0;
    r.param_word = '0;
    r.param_count = '0;
    status_q.push_back(r);
    walk = WALK_DROP;
  endfunction

  // Note one accepted request byte and queue the status it causes, if any.
  function void take_byte(logic [7:0] b, logic start);
    sspc_pkg::result_t r;
    logic [6:0] eb;
    if (start) begin
      clear_frame();
      if (b != sspc_pkg::HDR_BYTE) fault(sspc_pkg::ST_START_ID);
      else walk = WALK_HDR2;
      return;
    end
    case (walk)
      WALK_HDR2: begin
        if (b != sspc_pkg::HDR_BYTE) fault(sspc_pkg::ST_START_ID);
        else walk = WALK_ID;
      end
      WALK_ID: begin
        if (b != want_id) fault(sspc_pkg::ST_START_ID);
        else begin
          sum = b;
          walk = WALK_LEN;
        end
      end
      WALK_LEN: begin
        if (b < 2 || int'(b) - 2 > MAX_PARAMS) fault(sspc_pkg::ST_LENGTH);
        else begin
          len_byte = b;
          sum = sum + b;
          walk = WALK_ERR;
        end
      end
      WALK_ERR: begin
        err_byte = b;
        sum = sum + b;
        walk = (len_byte == 2) ? WALK_CHK : WALK_PARAM;
      end
      WALK_PARAM: begin
        if (param_idx == 0) p_lo = b;
        else if (param_idx == 1) p_hi = b;
        sum = sum + b;
        param_idx++;
        if (param_idx >= int'(len_byte) - 2) walk = WALK_CHK;
      end
      WALK_CHK: begin
        // Servo error bits win over the checksum; the lowest set bit decides.
        eb = err_byte[6:0];
        r.status = sspc_pkg::ST_OK;
        if (eb != 0) begin
          for (int i = sspc_pkg::ERR_BITS - 1; i >= 0; i--) begin
            if (eb[i]) r.status = 4'(i + 1);
          end
        end else if (b != ~sum) begin
          r.status = sspc_pkg::ST_CSUM_BAD;
        end
        r.servo_error = err_byte;
        r.param_word = {p_hi, p_lo};
        r.param_count = 4'(len_byte - 8'd2);
        status_q.push_back(r);
        walk = WALK_IDLE;
      end
      default: begin
      end
    endcase
  endfunction

  function string show(sspc_pkg::result_t r);
    return $sformatf("st=%0d err=%02h word=%04h cnt=%0d",
                     r.status, r.servo_error, r.param_word, r.param_count);
  endfunction

  function void note_fail(string what, sspc_pkg::result_t want, sspc_pkg::result_t got);
    fails++;
    if (fails <= 10) begin
      $display("%0t: %s: expected %s, got %s", $time, what, show(want), show(got));
    end
  endfunction

  // Compare one accepted status with the oldest one still expected.
  function void compare_status(sspc_pkg::result_t got);
    sspc_pkg::result_t want;
    if (status_q.size() == 0) begin
      want = '0;
      note_fail("unexpected status", want, got);
      return;
    end
    want = status_q.pop_front();
    if (got.status !== want.status || got.servo_error !== want.servo_error ||
        got.param_word !== want.param_word || got.param_count !== want.param_count) begin
      note_fail("status mismatch", want, got);
    end
  endfunction

  // Statuses that never arrived count as failures too.
  function int unsigned finish_check();
    sspc_pkg::result_t none;
    none = '0;
    while (status_q.size() != 0) note_fail("missing status", status_q.pop_front(), none);
    return fails;
  endfunction
endclass

module tb_servo_status_packet_checker;

  localparam int CYCLE_LIMIT = 400000;
  localparam int ITEM_GOAL   = 550;
  localparam int SETTLE      = 6;
  localparam int MAX_PARAMS  = sspc_pkg::MAX_PARAMS_DEF;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_rx_byte = 8'h00;
  logic        in_frame_start = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [3:0]  out_status;
  logic [7:0]  out_servo_error;
  logic [15:0] out_param_word;
  logic [3:0]  out_param_count;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_expected_id = 8'h00;

  reply_status_tracker tracker;
  int unsigned cycle_count = 0;
  int unsigned sent_items = 0;
  int          burst_left = 0;
  int          stall_run = 0;
  int          stall_mode = 0;

  servo_status_packet_checker uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_rx_byte      (in_rx_byte),
    .in_frame_start  (in_frame_start),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_servo_error (out_servo_error),
    .out_param_word  (out_param_word),
    .out_param_count (out_param_count),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_expected_id (cfg_expected_id)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Give up if the run hangs.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL servo_status_packet_checker");
      $finish;
    end
  end

  // The receiver switches between free flow, light and heavy stalling.
  always @(negedge clk) begin
    if (stall_run == 0) begin
      stall_mode = $urandom_range(0, 2);
      stall_run = $urandom_range(8, 60);
    end else begin
      stall_run--;
    end
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      default: out_stall <= ($urandom_range(0, 3) != 0);
    endcase
  end

  // Check every accepted status.
  always @(posedge clk) begin : sample_status
    sspc_pkg::result_t got;
    if (rst_n && out_valid && !out_stall) begin
      got.status = out_status;
      got.servo_error = out_servo_error;
      got.param_word = out_param_word;
      got.param_count = out_param_count;
      tracker.compare_status(got);
    end
  end

  // Offer one request byte in bursts with random gaps; starts and ends at a falling edge.
  task automatic send_byte(input logic [7:0] b, input logic start, input bit counted);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                               : $urandom_range(1, 10);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_rx_byte <= b;
    in_frame_start <= start;
    do @(posedge clk); while (in_stall);
    tracker.take_byte(b, start);
    if (counted) sent_items++;
    @(negedge clk);
  endtask

  // Build a reply and send its first keep bytes.
  task automatic send_reply(input logic [7:0] hdr1, input logic [7:0] hdr2,
                            input logic [7:0] id, input logic [7:0] len,
                            input logic [7:0] err, input bit bad_sum, input int keep);
    logic [7:0] bytes[$];
    logic [7:0] sum;
    logic [7:0] b;
    int np;
    int k;
    np = (len >= 2 && int'(len) - 2 <= MAX_PARAMS) ? int'(len) - 2 : 0;
    bytes = {hdr1, hdr2, id, len, err};
    sum = id + len + err;
    for (k = 0; k < np; k++) begin
      b = 8'($urandom);
      bytes.push_back(b);
      sum = sum + b;
    end
    bytes.push_back(bad_sum ? (~sum ^ 8'($urandom_range(1, 255))) : ~sum);
    for (k = 0; k < bytes.size() && k < keep; k++) send_byte(bytes[k], k == 0, 1'b1);
  endtask

  // Mostly well-formed replies with random content, the rest faults and noise.
  task automatic random_reply();
    int pick;
    logic [7:0] len;
    logic [7:0] err;
    logic [7:0] id;
    int sel;
    pick = $urandom_range(0, 99);
    len = 8'($urandom_range(2, MAX_PARAMS + 2));
    sel = $urandom_range(0, 19);
    err = (sel < 12) ? 8'h00 : (sel < 15) ? 8'h80 : 8'($urandom);
    if (pick < 60) begin
      send_reply(sspc_pkg::HDR_BYTE, sspc_pkg::HDR_BYTE, tracker.want_id, len, err,
                 $urandom_range(0, 3) == 0, 99);
    end else if (pick < 66) begin
      send_reply(8'($urandom_range(0, 254)), sspc_pkg::HDR_BYTE, tracker.want_id, len, err,
                 1'b0, 99);
    end else if (pick < 72) begin
      send_reply(sspc_pkg::HDR_BYTE, 8'($urandom_range(0, 254)), tracker.want_id, len, err,
                 1'b0, 99);
    end else if (pick < 80) begin
      do id = 8'($urandom); while (id == tracker.want_id);
      send_reply(sspc_pkg::HDR_BYTE, sspc_pkg::HDR_BYTE, id, len, err, 1'b0, 99);
    end else if (pick < 88) begin
      len = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 1))
                                        : 8'($urandom_range(MAX_PARAMS + 3, 255));
      send_reply(sspc_pkg::HDR_BYTE, sspc_pkg::HDR_BYTE, tracker.want_id, len, err,
                 1'b0, 99);
    end else if (pick < 94) begin
      // A reply cut short; the next start abandons it.
      send_reply(sspc_pkg::HDR_BYTE, sspc_pkg::HDR_BYTE, tracker.want_id, len, err, 1'b0,
                 $urandom_range(1, int'(len) + 3));
    end else begin
      repeat ($urandom_range(1, 3)) send_byte(8'($urandom), 1'b0, 1'b0);
    end
  endtask

  // Hold off the sender until every status has come and the pipeline is empty.
  task automatic drain();
    in_valid <= 1'b0;
    while (tracker.pending() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_id(input logic [7:0] v);
    cfg_valid <= 1'b1;
    cfg_expected_id <= v;
    do @(posedge clk); while (!cfg_ready);
    tracker.set_id(v);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin : stimulus
    logic [7:0] id_plan[4];
    int target;
    id_plan = '{8'd0, 8'd253, 8'd255, 8'd254};
    tracker = new();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: header, id and length faults, stray byte, reserved error bit.
    send_reply(8'h00, sspc_pkg::HDR_BYTE, sspc_pkg::EXPECTED_ID_RST, 8'd2, 8'h00, 1'b0, 1);
    send_reply(sspc_pkg::HDR_BYTE, 8'h00, sspc_pkg::EXPECTED_ID_RST, 8'd2, 8'h00, 1'b0, 2);
    send_reply(sspc_pkg::HDR_BYTE, sspc_pkg::HDR_BYTE, 8'h07, 8'd2, 8'h00, 1'b0, 3);
    send_reply(sspc_pkg::HDR_BYTE, sspc_pkg::HDR_BYTE, sspc_pkg::EXPECTED_ID_RST, 8'd1,
               8'h00, 1'b0, 4);
    send_reply(sspc_pkg::HDR_BYTE, sspc_pkg::HDR_BYTE, sspc_pkg::EXPECTED_ID_RST, 8'hFF,
               8'h00, 1'b0, 4);
    send_byte(8'h55, 1'b0, 1'b0);
    send_reply(sspc_pkg::HDR_BYTE, sspc_pkg::HDR_BYTE, sspc_pkg::EXPECTED_ID_RST, 8'd2,
               8'h80, 1'b0, 99);
    send_reply(sspc_pkg::HDR_BYTE, sspc_pkg::HDR_BYTE, sspc_pkg::EXPECTED_ID_RST, 8'd4,
               8'h7E, 1'b0, 99);

    // Random phases, each under a different expected id.
    target = ITEM_GOAL / 5;
    for (int p = 0; p < 5; p++) begin
      drain();
      write_id(p < 4 ? id_plan[p] : 8'($urandom_range(2, 252)));
      while (sent_items < target * (p + 1)) random_reply();
    end
    drain();

    if (tracker.finish_check() == 0) begin
      $display("PASS servo_status_packet_checker");
    end else begin
      $display("FAIL servo_status_packet_checker");
    end
    $finish;
  end

endmodule
